/* hdl/keyframe_track_sampler_macros.svh */
// assertion macros for the keyframe track sampler
`ifndef KEYFRAME_TRACK_SAMPLER_MACROS_SVH
`define KEYFRAME_TRACK_SAMPLER_MACROS_SVH

// implication checked on every clock edge outside reset
`define KTS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");

// next-cycle implication
`define KTS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");

`endif

/* hdl/kts_pkg.sv */
// ----------------------------------------------------------------------------
// kts_pkg
// shared types and constants of the keyframe track sampler
// ----------------------------------------------------------------------------
package kts_pkg;
	localparam int MaxKeys = 64;
	localparam int IdxW = $clog2(MaxKeys);
	localparam int CntW = 7;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [0:0] REG_KEY_COUNT = 1'd0;
	localparam logic [0:0] REG_STEP_MODE = 1'd1;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         key_index;
		logic signed [31:0] key_time;
		logic signed [31:0] key_value;
		logic signed [31:0] sample_time;
	} req_t;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic               sample_ok;
	} res_t;

	// queued work from the front part
	typedef struct packed {
		logic               is_load;
		logic [IdxW-1:0]    idx;
		logic signed [31:0] tval;
		logic signed [31:0] vval;
	} job_t;
endpackage

/* hdl/kts_ram.sv */
// ----------------------------------------------------------------------------
// kts_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module kts_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hdl/kts_front.sv */
// ----------------------------------------------------------------------------
// kts_front
// accepts requests, classifies them and queues work for the back part
// ----------------------------------------------------------------------------
module kts_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  kts_pkg::req_t req,
	output logic          busy,
	output logic          job_valid,
	output kts_pkg::job_t job,
	input  logic          job_pop
);
	import kts_pkg::*;

	// two-entry queue
	job_t       q_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;
	job_t       nj;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign job_valid = (cnt_q != 2'd0);
	assign job = q_q[rd_q];

	always_comb begin
		nj.is_load = (req.cmd == CMD_LOAD);
		nj.idx = req.key_index[IdxW-1:0];
		nj.tval = (req.cmd == CMD_LOAD) ? req.key_time : req.sample_time;
		nj.vval = req.key_value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= nj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (job_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_pop};
		end
	end
endmodule

/* hdl/kts_back.sv */
// ----------------------------------------------------------------------------
// kts_back
// key store, bracket search and restoring divider for one job at a time
// ----------------------------------------------------------------------------
module kts_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  kts_pkg::job_t job,
	output logic          job_pop,
	input  logic [6:0]    key_count,
	input  logic          step_mode,
	output logic          strobe,
	output kts_pkg::res_t result
);
	import kts_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FIRST = 7'b0000010,
		S_LAST  = 7'b0000100,
		S_SCAN  = 7'b0001000,
		S_MUL   = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_OUT   = 7'b1000000
	} st_t;

	st_t st_q;
	logic [IdxW-1:0] raddr, ptr_q, last_q;
	logic [31:0] t_rd, v_rd;
	logic we;
	logic signed [31:0] t_q, ta_q, va_q, res_q;
	logic [1:0] ph_q;
	logic [6:0] n_lim;
	logic [31:0] dt_q, den_q, mag_q;
	logic neg_q, ok_q;
	logic [63:0] rem_q;
	logic [31:0] quo_q;
	logic [6:0] bit_q;
	logic [32:0] trial;

	assign we = job_valid && (st_q == S_IDLE) && job.is_load;
	assign n_lim = (key_count > 7'(MaxKeys)) ? 7'(MaxKeys) : key_count;

	kts_ram #(.Width(32), .Depth(MaxKeys)) u_times (
		.clk(clk), .we(we), .waddr(job.idx), .wdata(job.tval),
		.raddr(raddr), .rdata(t_rd));
	kts_ram #(.Width(32), .Depth(MaxKeys)) u_values (
		.clk(clk), .we(we), .waddr(job.idx), .wdata(job.vval),
		.raddr(raddr), .rdata(v_rd));

	assign raddr = ptr_q;
	assign job_pop = job_valid && (st_q == S_IDLE);
	// upper word of the product is below the divisor, so 32 steps give the quotient
	assign trial = rem_q[63:31] - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ph_q <= '0;
			ptr_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (job_valid && !job.is_load) begin
						t_q <= job.tval;
						if (n_lim == 7'd0) begin
							ok_q <= 1'b0;
							res_q <= '0;
							st_q <= S_OUT;
						end else begin
							ok_q <= 1'b1;
							last_q <= IdxW'(n_lim - 7'd1);
							ptr_q <= '0;
							ph_q <= '0;
							st_q <= S_FIRST;
						end
					end
				end
				S_FIRST: begin
					// wait for read of key 0, then issue last key
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
						ptr_q <= last_q;
					end else begin
						ta_q <= t_rd;
						va_q <= v_rd;
						ph_q <= '0;
						if (t_q <= $signed(t_rd)) begin
							res_q <= v_rd;
							st_q <= S_OUT;
						end else begin
							st_q <= S_LAST;
						end
					end
				end
				S_LAST: begin
					if (t_q >= $signed(t_rd)) begin
						res_q <= v_rd;
						st_q <= S_OUT;
					end else begin
						res_q <= v_rd;
						ptr_q <= IdxW'(1);
						ph_q <= '0;
						st_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// ta/va hold key ptr-1; the key ram read is registered
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						if (t_q >= ta_q && t_q <= $signed(t_rd)) begin
							if (step_mode || ta_q == $signed(t_rd)) begin
								res_q <= va_q;
								st_q <= S_OUT;
							end else begin
								dt_q <= 32'(t_q - ta_q);
								den_q <= 32'($signed(t_rd) - ta_q);
								neg_q <= $signed(v_rd) < va_q;
								mag_q <= ($signed(v_rd) < va_q) ?
									32'(va_q - $signed(v_rd)) : 32'($signed(v_rd) - va_q);
								st_q <= S_MUL;
							end
						end else if ({1'b0, ptr_q} == {1'b0, last_q}) begin
							st_q <= S_OUT;
						end else begin
							ta_q <= t_rd;
							va_q <= v_rd;
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				S_MUL: begin
					rem_q <= 64'(dt_q) * 64'(mag_q);
					quo_q <= '0;
					bit_q <= 7'd32;
					st_q <= S_DIV;
				end
				S_DIV: begin
					// restoring division, one quotient bit a cycle
					if (bit_q == 7'd0) begin
						res_q <= neg_q ? 32'(va_q - $signed(quo_q))
							: 32'(va_q + $signed(quo_q));
						st_q <= S_OUT;
					end else begin
						bit_q <= bit_q - 7'd1;
						quo_q <= {quo_q[30:0], ~trial[32]};
						rem_q <= {trial[32] ? rem_q[62:31] : trial[31:0], rem_q[30:0], 1'b0};
					end
				end
				S_OUT: begin
					strobe <= 1'b1;
					result.sample_value <= res_q;
					result.sample_ok <= ok_q;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hdl/keyframe_track_sampler.sv */
// a load is written into the key ram when the back part pops it from the queue;
// one sample is handled at a time, through the bracket scan over the key ram
// and the 32-step restoring divider
// a two-entry queue takes new requests while a sample runs
// results cannot be stalled; reset clears control and the config registers, not the keys
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// keyframe track with linear or step sampling
// ----------------------------------------------------------------------------
module keyframe_track_sampler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  kts_pkg::req_t req,
	output logic          busy,
	output logic          strobe,
	output kts_pkg::res_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [0:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import kts_pkg::*;

	logic       job_valid, job_pop;
	job_t       job;
	logic [6:0] key_count_q;
	logic       step_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			step_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY_COUNT: key_count_q <= cfg_data[6:0];
				REG_STEP_MODE: step_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	kts_front u_front (
		.clk, .arst_n, .start, .req, .busy,
		.job_valid, .job, .job_pop);

	kts_back u_back (
		.clk, .arst_n, .job_valid, .job, .job_pop,
		.key_count(key_count_q), .step_mode(step_mode_q),
		.strobe, .result);
endmodule

/* hdl/kts_checker.sv */
// ----------------------------------------------------------------------------
// kts_checker
// port-level checks of the keyframe track sampler
// ----------------------------------------------------------------------------
`include "keyframe_track_sampler_macros.svh"
module kts_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          strobe,
	input kts_pkg::res_t result
);
	`KTS_ASSERT_NEXT(a_strobe_single, clk, arst_n, strobe, !strobe)
	`KTS_ASSERT_IMP(a_fail_zero, clk, arst_n, strobe && !result.sample_ok,
		result.sample_value == 32'sd0)
	`KTS_ASSERT_NEXT(a_busy_after_idle, clk, arst_n, !busy && !start, !busy)
endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (
	.clk, .arst_n, .start, .busy, .strobe, .result);
